@@ hw/rtl/flpte_pkg.sv @@
// ----------------------------------------------------------------------------
// flpte_pkg
// Shared types and constants of the four-level page-table engine: entry
// layout, memory control word, operation and status codes.
// ----------------------------------------------------------------------------
package flpte_pkg;

    localparam int IDX_W    = 9;
    localparam int PFN_W    = 40;
    localparam int OFFSET_W = 12;
    localparam int ENTRY_W  = 64;
    localparam int VA_W     = 48;
    localparam int PA_W     = 52;

    // Low bit of the virtual address index field at each level.
    localparam int L0_SHIFT = 39;
    localparam int L1_SHIFT = 30;
    localparam int L2_SHIFT = 21;
    localparam int L3_SHIFT = 12;

    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_DIR  = 2'd1;
    localparam logic [1:0] LVL_MID  = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    localparam logic [ENTRY_W-1:0] LINK_FLAGS  = 64'h7;
    localparam logic [ENTRY_W-1:0] PRESENT_BIT = 64'h1;

    localparam logic [1:0] MODE_MAP   = 2'd0;
    localparam logic [1:0] MODE_UNMAP = 2'd1;
    localparam logic [1:0] MODE_XLATE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAME = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    // One stored entry. fresh marks an entry written while its frame was
    // already handed out, so that allocation zeroes a frame without a sweep.
    typedef struct packed {
        logic                 fresh;
        logic [ENTRY_W-1:0]   value;
    } entry_t;

    typedef struct packed {
        logic en;
        logic we;
    } mem_ctrl_t;

endpackage

@@ hw/rtl/flpte_store.sv @@
// ----------------------------------------------------------------------------
// flpte_store
// Single-port table memory with a registered read port.
// ----------------------------------------------------------------------------
module flpte_store #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic                 clk,
    input  flpte_pkg::mem_ctrl_t ctrl,
    input  logic [AW-1:0]        addr,
    input  flpte_pkg::entry_t    wdata,
    output flpte_pkg::entry_t    rdata
);

    flpte_pkg::entry_t mem [DEPTH];
    flpte_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            if (ctrl.we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/flpte_ctrl.sv @@
// ----------------------------------------------------------------------------
// flpte_ctrl
// Walk sequencer: clears the store after reset, then reads each level,
// allocates and links missing frames, and writes or inspects the leaf.
// ----------------------------------------------------------------------------
module flpte_ctrl #(
    parameter int TABLE_FRAMES = 64,
    parameter int FW           = 6,
    parameter int NW           = 7,
    parameter int AW           = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic [flpte_pkg::VA_W-1:0]        virt_addr,
    input  logic [flpte_pkg::PA_W-1:0]        phys_addr,
    input  logic [flpte_pkg::ENTRY_W-1:0]     leaf_flags,
    input  logic [flpte_pkg::PFN_W-1:0]       base_pfn,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [flpte_pkg::PA_W-1:0]        phys_out,
    output flpte_pkg::mem_ctrl_t              mem_ctrl,
    output logic [AW-1:0]                     mem_addr,
    output flpte_pkg::entry_t                 mem_wdata,
    input  flpte_pkg::entry_t                 mem_rdata
);

    localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_FRAMES * 512 - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL
    } state_t;

    state_t                                 state_reg, state_next;
    logic [AW-1:0]                          clr_addr_reg, clr_addr_next;
    logic [1:0]                             lvl_reg, lvl_next;
    logic [FW-1:0]                          frame_reg, frame_next;
    logic [NW-1:0]                          free_reg, free_next;
    logic [1:0]                             mode_reg, mode_next;
    logic [flpte_pkg::VA_W-1:0]             va_reg, va_next;
    logic [flpte_pkg::PFN_W-1:0]            pa_pfn_reg, pa_pfn_next;
    logic [flpte_pkg::ENTRY_W-1:0]          flags_reg, flags_next;
    logic                                   done_reg, done_next;
    logic [1:0]                             status_reg, status_next;
    logic [flpte_pkg::PA_W-1:0]             phys_reg, phys_next;

    logic [flpte_pkg::IDX_W-1:0]            idx;
    logic                                   frame_live;
    logic [flpte_pkg::ENTRY_W-1:0]          eff_entry;
    logic [flpte_pkg::PFN_W-1:0]            eff_pfn;
    logic [flpte_pkg::PFN_W-1:0]            link_off;
    logic                                   link_ok;
    logic                                   can_alloc;
    logic [flpte_pkg::PFN_W-1:0]            new_pfn;

    always_comb
    begin
        case (lvl_reg)
            flpte_pkg::LVL_TOP: idx = va_reg[flpte_pkg::L0_SHIFT +: flpte_pkg::IDX_W];
            flpte_pkg::LVL_DIR: idx = va_reg[flpte_pkg::L1_SHIFT +: flpte_pkg::IDX_W];
            flpte_pkg::LVL_MID: idx = va_reg[flpte_pkg::L2_SHIFT +: flpte_pkg::IDX_W];
            default:            idx = va_reg[flpte_pkg::L3_SHIFT +: flpte_pkg::IDX_W];
        endcase
    end

    // A frame already handed out reads as zero wherever it has not been
    // written since its allocation.
    assign frame_live = NW'(frame_reg) < free_reg;
    assign eff_entry  = (frame_live && !mem_rdata.fresh) ? '0 : mem_rdata.value;
    assign eff_pfn    = eff_entry[flpte_pkg::OFFSET_W +: flpte_pkg::PFN_W];
    assign link_off   = eff_pfn - base_pfn;
    assign link_ok    = link_off < flpte_pkg::PFN_W'(TABLE_FRAMES);
    assign can_alloc  = free_reg < NW'(TABLE_FRAMES);
    assign new_pfn    = flpte_pkg::PFN_W'(free_reg) + base_pfn;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        lvl_next      = lvl_reg;
        frame_next    = frame_reg;
        free_next     = free_reg;
        mode_next     = mode_reg;
        va_next       = va_reg;
        pa_pfn_next   = pa_pfn_reg;
        flags_next    = flags_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        phys_next     = phys_reg;

        mem_ctrl        = '0;
        mem_addr        = {frame_reg, idx};
        mem_wdata.fresh = frame_live;
        mem_wdata.value = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_ctrl.en     = 1'b1;
                mem_ctrl.we     = 1'b1;
                mem_addr        = clr_addr_reg;
                mem_wdata.fresh = 1'b0;
                clr_addr_next   = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    mode_next   = mode;
                    va_next     = virt_addr;
                    pa_pfn_next = phys_addr[flpte_pkg::OFFSET_W +: flpte_pkg::PFN_W];
                    flags_next  = leaf_flags;
                    lvl_next    = flpte_pkg::LVL_TOP;
                    frame_next  = '0;
                    if (mode inside {flpte_pkg::MODE_MAP, flpte_pkg::MODE_UNMAP,
                                     flpte_pkg::MODE_XLATE})
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = flpte_pkg::ST_FAIL;
                        phys_next   = '0;
                    end
                end
            end

            S_READ:
            begin
                mem_ctrl.en = 1'b1;
                state_next  = S_EVAL;
            end

            S_EVAL:
            begin
                phys_next = '0;
                if (lvl_reg != flpte_pkg::LVL_LEAF)
                begin
                    if (eff_entry[0])
                    begin
                        if (link_ok)
                        begin
                            frame_next = link_off[FW-1:0];
                            lvl_next   = lvl_reg + 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            status_next = flpte_pkg::ST_FAIL;
                            state_next  = S_IDLE;
                        end
                    end
                    else if (mode_reg == flpte_pkg::MODE_MAP && can_alloc)
                    begin
                        // Link a fresh frame; it reads as zero from now on.
                        // The link lands after that clearing, so it stays
                        // visible even when it sits in the frame handed out.
                        mem_ctrl.en     = 1'b1;
                        mem_ctrl.we     = 1'b1;
                        mem_wdata.fresh = (NW'(frame_reg) <= free_reg);
                        mem_wdata.value = flpte_pkg::LINK_FLAGS |
                                          {12'h000, new_pfn, 12'h000};
                        frame_next      = free_reg[FW-1:0];
                        free_next       = free_reg + 1'b1;
                        lvl_next        = lvl_reg + 1'b1;
                        state_next      = S_READ;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = flpte_pkg::ST_FAIL;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    case (mode_reg)
                        flpte_pkg::MODE_MAP:
                        begin
                            if (eff_entry[0])
                            begin
                                status_next = (eff_pfn == pa_pfn_reg) ?
                                              flpte_pkg::ST_SAME : flpte_pkg::ST_FAIL;
                            end
                            else
                            begin
                                mem_ctrl.en     = 1'b1;
                                mem_ctrl.we     = 1'b1;
                                mem_wdata.value = flags_reg | flpte_pkg::PRESENT_BIT |
                                                  {12'h000, pa_pfn_reg, 12'h000};
                                status_next     = flpte_pkg::ST_OK;
                            end
                        end
                        flpte_pkg::MODE_UNMAP:
                        begin
                            mem_ctrl.en = 1'b1;
                            mem_ctrl.we = 1'b1;
                            status_next = flpte_pkg::ST_OK;
                        end
                        default:
                        begin
                            if (eff_entry[0])
                            begin
                                status_next = flpte_pkg::ST_OK;
                                phys_next   = {eff_pfn,
                                               va_reg[flpte_pkg::OFFSET_W-1:0]};
                            end
                            else
                            begin
                                status_next = flpte_pkg::ST_FAIL;
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            lvl_reg      <= flpte_pkg::LVL_TOP;
            frame_reg    <= '0;
            free_reg     <= NW'(1);
            mode_reg     <= flpte_pkg::MODE_MAP;
            va_reg       <= '0;
            pa_pfn_reg   <= '0;
            flags_reg    <= '0;
            done_reg     <= 1'b0;
            status_reg   <= flpte_pkg::ST_OK;
            phys_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            lvl_reg      <= lvl_next;
            frame_reg    <= frame_next;
            free_reg     <= free_next;
            mode_reg     <= mode_next;
            va_reg       <= va_next;
            pa_pfn_reg   <= pa_pfn_next;
            flags_reg    <= flags_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            phys_reg     <= phys_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign phys_out = phys_reg;

endmodule

@@ hw/rtl/four_level_page_table_engine_core.sv @@
// ----------------------------------------------------------------------------
// four_level_page_table_engine_core
// Four-level radix page table held in one single-port memory, with map,
// unmap and translate of single 4 KiB pages.
// ----------------------------------------------------------------------------
// Walk: each level reached is a memory read (S_READ), then an evaluate or
// write (S_EVAL); the result word is registered and strobed on done after
// the last evaluate. Early failures stop at their level; an unknown mode is
// answered from idle with no memory access. A new request is taken only in
// idle, so walks never overlap. Reset: the store is swept to zero with busy
// high; results are strobed on done and cannot be stalled.
// ----------------------------------------------------------------------------
module four_level_page_table_engine_core #(
    parameter int TABLE_FRAMES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic [flpte_pkg::VA_W-1:0]        virt_addr,
    input  logic [flpte_pkg::PA_W-1:0]        phys_addr,
    input  logic [flpte_pkg::ENTRY_W-1:0]     leaf_flags,
    input  logic                              cfg_we,
    input  logic [flpte_pkg::PFN_W-1:0]       cfg_wdata,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [flpte_pkg::PA_W-1:0]        phys_out
);

    localparam int FW    = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int NW    = $clog2(TABLE_FRAMES + 1);
    localparam int DEPTH = TABLE_FRAMES * 512;
    localparam int AW    = FW + flpte_pkg::IDX_W;

    logic [flpte_pkg::PFN_W-1:0] table_base_pfn_reg;

    flpte_pkg::mem_ctrl_t mem_ctrl;
    logic [AW-1:0]        mem_addr;
    flpte_pkg::entry_t    mem_wdata;
    flpte_pkg::entry_t    mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_pfn_reg <= '0;
        end
        else if (cfg_we)
        begin
            table_base_pfn_reg <= cfg_wdata;
        end
    end

    flpte_ctrl #(
        .TABLE_FRAMES (TABLE_FRAMES),
        .FW           (FW),
        .NW           (NW),
        .AW           (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .virt_addr  (virt_addr),
        .phys_addr  (phys_addr),
        .leaf_flags (leaf_flags),
        .base_pfn   (table_base_pfn_reg),
        .done       (done),
        .status     (status),
        .phys_out   (phys_out),
        .mem_ctrl   (mem_ctrl),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata)
    );

    flpte_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
